// ----- rtl/mtgl_pkg.sv -----
`timescale 1ns / 1ps

package mtgl_pkg;

    // Widths of the input and output words.
    localparam int COL_W   = 6;
    localparam int PAGE_W  = 4;
    localparam int TILE_W  = 64;
    localparam int BYTE_W  = 8;

    // Each tile becomes three command bytes followed by 32 data bytes.
    localparam int NUM_CMD   = 3;
    localparam int NUM_BYTES = 35;
    localparam int IDX_W     = 6;

    localparam logic [IDX_W-1:0] IDX_PAGE   = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_COL_HI = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_COL_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_FIRST_DATA = IDX_W'(NUM_CMD);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(NUM_BYTES - 1);

    // Controller command opcodes and gray nibble patterns.
    localparam logic [BYTE_W-1:0] CMD_SET_PAGE   = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_SET_COL_HI = 8'h10;
    localparam logic [BYTE_W-1:0] GRAY_HI_ON     = 8'hF0;
    localparam logic [BYTE_W-1:0] GRAY_LO_ON     = 8'h0F;

endpackage

// ----- rtl/mtgl_tile_if.sv -----
`timescale 1ns / 1ps

interface mtgl_tile_if;
    import mtgl_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  tile_column;
    logic [PAGE_W-1:0] page;
    logic [TILE_W-1:0] tile_bits;

    modport source (output valid, output tile_column, output page, output tile_bits,
                    input ready);
    modport sink   (input valid, input tile_column, input page, input tile_bits,
                    output ready);
endinterface

// ----- rtl/mtgl_byte_if.sv -----
`timescale 1ns / 1ps

interface mtgl_byte_if;
    import mtgl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              last;

    modport source (output valid, output out_byte, output is_data, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_data, input last,
                    output ready);
endinterface

// ----- rtl/mono_tile_to_gray_lcd_stream.sv -----
`timescale 1ns / 1ps

// Monochrome 8x8 tile to 16-level grayscale LCD byte stream.
//
// Channels: i_tile takes one word per tile (tile column, page and the eight
// column bytes of the tile). o_lcd sends one byte word per cycle while not
// stalled: three command bytes that set page and column, then 32 pixel data
// bytes, with is_data low on commands and last high on the final data byte.
//
// Once a tile word is accepted into the tile register, its first command byte
// moves to the output register, which drives o_lcd, when that register is free.
// The tile register takes the next tile in the same cycle that the last byte of
// the current one moves to the output register, so back-to-back tiles stream
// without a gap.
//
// Reset clears the busy flag and the output valid; a tile in progress is
// dropped. When the receiver stalls, the output register holds its byte, the
// byte counter stops, and i_tile.ready stays low until the last byte of the
// current tile is on its way.
module mono_tile_to_gray_lcd_stream
    import mtgl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtgl_tile_if.sink   i_tile,
    mtgl_byte_if.source o_lcd
);

    // Tile holding register and byte counter.
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    logic [COL_W-1:0]  r_col;
    logic [PAGE_W-1:0] r_page;
    logic [TILE_W-1:0] r_bits;

    // Output register.
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_is_data;
    logic              r_out_last;

    logic              advance;
    logic              tile_done;
    logic              tile_take;
    logic [BYTE_W-1:0] n_byte;
    logic [BYTE_W-1:0] col_addr;
    logic [IDX_W-1:0]  data_idx;
    logic [2:0]        row;
    logic [1:0]        pair;
    logic [5:0]        hi_pos;
    logic [5:0]        lo_pos;

    // While a tile is held, a byte moves to the output register whenever that
    // register is free or being emptied this cycle.
    assign advance   = r_busy && (!r_out_valid || o_lcd.ready);
    assign tile_done = advance && (r_idx == IDX_LAST);
    assign tile_take = i_tile.valid && i_tile.ready;

    assign i_tile.ready = !r_busy || tile_done;

    // Data byte 4*row+pair takes its high nibble from tile byte 2*pair and its
    // low nibble from tile byte 2*pair+1, both at bit position row.
    assign col_addr = {r_col, 2'b00};
    assign data_idx = r_idx - IDX_FIRST_DATA;
    assign row      = data_idx[4:2];
    assign pair     = data_idx[1:0];
    assign hi_pos   = {pair, 1'b0, row};
    assign lo_pos   = {pair, 1'b1, row};

    always_comb begin
        case (r_idx)
            IDX_PAGE: begin
                n_byte = CMD_SET_PAGE | {4'h0, r_page};
            end
            IDX_COL_HI: begin
                n_byte = CMD_SET_COL_HI | {4'h0, col_addr[7:4]};
            end
            IDX_COL_LO: begin
                n_byte = {4'h0, col_addr[3:0]};
            end
            default: begin
                n_byte = (r_bits[hi_pos] ? GRAY_HI_ON : '0)
                       | (r_bits[lo_pos] ? GRAY_LO_ON : '0);
            end
        endcase
    end

    // Control state: busy flag and byte counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (tile_take) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (tile_done) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Tile payload.
    always_ff @(posedge i_clk) begin
        if (tile_take) begin
            r_col  <= i_tile.tile_column;
            r_page <= i_tile.page;
            r_bits <= i_tile.tile_bits;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_lcd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte    <= n_byte;
            r_out_is_data <= (r_idx >= IDX_FIRST_DATA);
            r_out_last    <= (r_idx == IDX_LAST);
        end
    end

    assign o_lcd.valid    = r_out_valid;
    assign o_lcd.out_byte = r_out_byte;
    assign o_lcd.is_data  = r_out_is_data;
    assign o_lcd.last     = r_out_last;

    // The counter never runs past the final byte of a tile.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= IDX_LAST))
        else $error("byte counter out of range");

    // A new tile is taken while busy only as the final byte leaves.
    a_take_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tile_take && r_busy) |-> (r_idx == IDX_LAST && advance))
        else $error("tile accepted in the middle of a tile");

    // The last word of a tile is always a data byte.
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lcd.valid && o_lcd.last) |-> o_lcd.is_data)
        else $error("last flag on a command byte");

    // Each tile opens with a page command right after it is taken.
    a_page_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tile_take |=> (r_busy && r_idx == IDX_PAGE))
        else $error("tile does not start at the page command");

endmodule
